### rtl/btpc_pkg.sv
package btpc_pkg;

    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;
    localparam int CAL_W  = 168;
    localparam int HI_W   = 40;
    localparam int ACC_W  = 128;
    localparam int MP_W   = 25;
    localparam int CNT_W  = 5;
    localparam int DAT_W  = 24;

    localparam logic [IDX_W-1:0] REG_CAL_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_CAL_MID  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CAL_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_END,
        ST_OUT
    } t_state;

    // One multiply-accumulate per code: acc = addend + mcand * mplier
    typedef enum logic [3:0] {
        OP_T1,
        OP_T2,
        OP_P0A,
        OP_P0B,
        OP_P0C,
        OP_P1A,
        OP_P1B,
        OP_P1C,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_P5
    } t_op;

    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic finish;
        logic emit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

### rtl/btpc_in_if.sv
interface btpc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
    logic        temperature_ok;
    logic        pressure_ok;

    modport source (output valid, raw_temperature, raw_pressure, temperature_ok, pressure_ok,
                    input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, temperature_ok, pressure_ok,
                    output ready);
endinterface

### rtl/btpc_out_if.sv
interface btpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature;
    logic        [23:0] pressure;

    modport source (output valid, temperature, pressure, input ready);
    modport sink   (input valid, temperature, pressure, output ready);
endinterface

### rtl/btpc_datapath.sv
module btpc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [btpc_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [btpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [btpc_pkg::DAT_W-1:0]     i_raw_temperature,
    input  logic [btpc_pkg::DAT_W-1:0]     i_raw_pressure,
    input  btpc_pkg::t_cmd                 i_cmd,
    output btpc_pkg::t_sts                 o_sts,
    output logic signed [btpc_pkg::DAT_W-1:0] o_temperature,
    output logic [btpc_pkg::DAT_W-1:0]     o_pressure
);
    import btpc_pkg::*;

    logic [CFG_W-1:0] r_cal_lo, r_cal_mid;
    logic [HI_W-1:0]  r_cal_hi;
    logic [CAL_W-1:0] cal;

    logic [DAT_W-1:0] r_rawp;
    logic signed [MP_W-1:0] r_d;
    logic signed [DAT_W-1:0] r_temp, n_temp;
    logic [DAT_W-1:0] r_pres, n_pres;
    logic signed [DAT_W-1:0] r_out_t;
    logic [DAT_W-1:0] r_out_p;

    logic signed [ACC_W-1:0] r_acc, r_mc, r_s0, r_s1;
    logic signed [MP_W-1:0]  r_mp;
    logic [CNT_W-1:0]        r_cnt;

    logic signed [ACC_W-1:0] c_t2, c_t3, c_p1, c_p2, c_p3, c_p4, c_p5, c_p6;
    logic signed [ACC_W-1:0] c_p7, c_p8, c_p9, c_p10, c_p11;
    logic signed [ACC_W-1:0] sel_add, sel_mc;
    logic signed [MP_W-1:0]  sel_mp;
    logic [ACC_W-56:0]       t_hi;

    assign cal = {r_cal_hi, r_cal_mid, r_cal_lo};

    // coefficients, already scaled to a common 2^-85 Pa (or 2^-48 degC) grid
    assign c_t2  = ACC_W'($signed({1'b0, cal[31:16]})) <<< 18;
    assign c_t3  = ACC_W'($signed(cal[39:32]));
    assign c_p1  = (ACC_W'($signed(cal[55:40])) - ACC_W'(16384)) <<< 65;
    assign c_p2  = (ACC_W'($signed(cal[71:56])) - ACC_W'(16384)) <<< 40;
    assign c_p3  = ACC_W'($signed(cal[79:72])) <<< 21;
    assign c_p4  = ACC_W'($signed(cal[87:80]));
    assign c_p5  = ACC_W'($signed({1'b0, cal[103:88]})) <<< 88;
    assign c_p6  = ACC_W'($signed({1'b0, cal[119:104]})) <<< 63;
    assign c_p7  = ACC_W'($signed(cal[127:120])) <<< 45;
    assign c_p8  = ACC_W'($signed(cal[135:128])) <<< 22;
    assign c_p9  = ACC_W'($signed(cal[151:136])) <<< 37;
    assign c_p10 = ACC_W'($signed(cal[159:152])) <<< 21;
    assign c_p11 = ACC_W'($signed(cal[167:160])) <<< 20;

    always_comb begin
        sel_add = '0;
        sel_mc  = r_acc;
        sel_mp  = MP_W'(r_temp);
        case (i_cmd.op)
            OP_T1: begin
                sel_add = c_t2;  sel_mc = c_t3;  sel_mp = r_d;
            end
            OP_T2: begin
                sel_add = '0;    sel_mp = r_d;
            end
            OP_P0A: begin
                sel_add = c_p7;  sel_mc = c_p8;
            end
            OP_P0B: sel_add = c_p6;
            OP_P0C: sel_add = c_p5;
            OP_P1A: begin
                sel_add = c_p3;  sel_mc = c_p4;
            end
            OP_P1B: sel_add = c_p2;
            OP_P1C: sel_add = c_p1;
            OP_P2: begin
                sel_add = c_p9;  sel_mc = c_p10;
            end
            OP_P3: begin
                sel_add = r_acc; sel_mc = c_p11; sel_mp = $signed({1'b0, r_rawp});
            end
            OP_P4: begin
                sel_add = r_s1;  sel_mp = $signed({1'b0, r_rawp});
            end
            OP_P5: begin
                sel_add = r_s0;  sel_mp = $signed({1'b0, r_rawp});
            end
            default: sel_add = '0;
        endcase
    end

    // floor to 2^-16 degC, then clamp to the signed 24-bit range
    assign t_hi = r_acc[ACC_W-1:55];
    always_comb begin
        if (&t_hi || ~|t_hi) begin
            n_temp = r_acc[55:32];
        end else if (r_acc[ACC_W-1]) begin
            n_temp = {1'b1, {(DAT_W-1){1'b0}}};
        end else begin
            n_temp = {1'b0, {(DAT_W-1){1'b1}}};
        end
    end

    // floor to 2^-6 Pa, clamp to 0..2^24-1
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            n_pres = '0;
        end else if (|r_acc[ACC_W-2:103]) begin
            n_pres = '1;
        end else begin
            n_pres = r_acc[102:79];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_lo  <= '0;
            r_cal_mid <= '0;
            r_cal_hi  <= '0;
            r_temp    <= '0;
            r_pres    <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAL_LOW:  r_cal_lo  <= i_cfg_data;
                    REG_CAL_MID:  r_cal_mid <= i_cfg_data;
                    REG_CAL_HIGH: r_cal_hi  <= i_cfg_data[HI_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.finish) begin
                case (i_cmd.op)
                    OP_T2:   r_temp <= n_temp;
                    OP_P5:   r_pres <= n_pres;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rawp <= i_raw_pressure;
            r_d    <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, cal[15:0], 8'd0});
        end
        if (i_cmd.start) begin
            r_acc <= sel_add;
            r_mc  <= sel_mc;
            r_mp  <= sel_mp;
        end else if (i_cmd.step) begin
            // LSB-first shift-add; the top multiplier bit carries negative weight
            if (r_mp[0]) begin
                if (r_cnt == CNT_W'(MP_W - 1)) begin
                    r_acc <= r_acc - r_mc;
                end else begin
                    r_acc <= r_acc + r_mc;
                end
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >>> 1;
        end
        if (i_cmd.finish) begin
            if (i_cmd.op == OP_P0C) begin
                r_s0 <= r_acc;
            end
            if (i_cmd.op == OP_P1C) begin
                r_s1 <= r_acc;
            end
        end
        if (i_cmd.emit) begin
            r_out_t <= r_temp;
            r_out_p <= r_pres;
        end
    end

    assign o_sts.last    = (r_cnt == CNT_W'(MP_W - 1));
    assign o_temperature = r_out_t;
    assign o_pressure    = r_out_p;

endmodule

### rtl/btpc_ctrl.sv
module btpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_temperature_ok,
    input  logic           i_pressure_ok,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output btpc_pkg::t_cmd o_cmd,
    input  btpc_pkg::t_sts i_sts
);
    import btpc_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_pok, n_pok;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_T1;
            r_pok       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_pok       <= n_pok;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pok       = r_pok;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '{capture: 1'b0, start: 1'b0, step: 1'b0, finish: 1'b0,
                        emit: 1'b0, op: r_op};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_pok         = i_pressure_ok;
                    if (i_temperature_ok) begin
                        n_op    = OP_T1;
                        n_state = ST_START;
                    end else if (i_pressure_ok) begin
                        n_op    = OP_P0A;
                        n_state = ST_START;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_END;
                end
            end
            ST_END: begin
                o_cmd.finish = 1'b1;
                if (r_op == OP_P5 || (r_op == OP_T2 && !r_pok)) begin
                    n_state = ST_OUT;
                end else begin
                    n_op    = t_op'(4'(r_op) + 4'd1);
                    n_state = ST_START;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("accepted word did not start work");
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && i_sts.last) |=> r_state == ST_END)
        else $error("multiply did not end on last bit");
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result raised outside output state");
    a_pressure_ops_need_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START && r_op != OP_T1 && r_op != OP_T2) |-> r_pok)
        else $error("pressure work without pressure flag");
`endif

endmodule

### rtl/baro_temp_pressure_compensation.sv
// channel   dir  payload                                              handshake
// i_in      in   raw_temperature, raw_pressure, temperature_ok,       valid/ready
//                pressure_ok
// o_out     out  temperature (signed), pressure                       valid/ready
// i_cfg_*   in   index, 64-bit data                                   write enable
//
// A word runs only the multiply-accumulates its flags call for, none with both flags
// clear; each of the 12 multiply-accumulates runs on one shared 128-bit shift-add
// unit (25 multiplier bits, plus load and writeback).
// Synchronous active-low reset clears calibration, stored readings and control.
// A new word is taken once the previous result sits in the output register, even
// if it is not yet taken; output stalls only hold the block at its final step.
module baro_temp_pressure_compensation (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    btpc_in_if.sink                    i_in,
    btpc_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [btpc_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [btpc_pkg::CFG_W-1:0] i_cfg_data
);
    import btpc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    btpc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .o_in_ready       (i_in.ready),
        .i_temperature_ok (i_in.temperature_ok),
        .i_pressure_ok    (i_in.pressure_ok),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_cmd            (cmd),
        .i_sts            (sts)
    );

    btpc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_raw_temperature (i_in.raw_temperature),
        .i_raw_pressure    (i_in.raw_pressure),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_temperature     (o_out.temperature),
        .o_pressure        (o_out.pressure)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import btpc_pkg::*;

    typedef struct {
        logic [23:0] raw_t;
        logic [23:0] raw_p;
        logic        t_ok;
        logic        p_ok;
    } t_reading;

    typedef struct {
        logic signed [23:0] temp;
        logic        [23:0] pres;
    } t_comp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    btpc_in_if  in_ch ();
    btpc_out_if out_ch ();

    baro_temp_pressure_compensation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [63:0]        cal_reg [3];
    logic signed [23:0] held_temp;
    logic        [23:0] held_pres;

    t_reading reading_q [$];
    t_comp    comp_q [$];
    t_reading on_bus;
    bit       no_idle = 0;
    bit       hold_go = 0;
    bit       hold_done = 0;
    int       hold_left = 0;
    int       n_err = 0;
    int       n_words = 0;
    int       n_results = 0;
    int       n_sat = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] cal_byte(int i);
        logic [167:0] all;
        all = {cal_reg[2][39:0], cal_reg[1], cal_reg[0]};
        return all[8*i +: 8];
    endfunction

    function automatic longint cal_u16(int i);
        return longint'({48'd0, cal_byte(i + 1), cal_byte(i)});
    endfunction

    function automatic longint cal_s16(int i);
        logic signed [15:0] v;
        v = {cal_byte(i + 1), cal_byte(i)};
        return longint'(v);
    endfunction

    function automatic longint cal_s8(int i);
        logic signed [7:0] v;
        v = cal_byte(i);
        return longint'(v);
    endfunction

    function automatic logic signed [127:0] scaled(longint a, longint b, int k);
        logic signed [127:0] x, y;
        x = 128'(a);
        y = 128'(b);
        return (x * y) <<< k;
    endfunction

    function automatic logic signed [23:0] calc_temp(logic [23:0] raw);
        longint d, s, q;
        d = longint'({40'd0, raw}) - cal_u16(0) * 256;
        s = d * cal_u16(2) * 262144 + d * d * cal_s8(4);
        q = s >>> 32;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[23:0];
    endfunction

    function automatic logic [23:0] calc_pres(logic [23:0] raw, logic signed [23:0] temp);
        longint pr, tc, t2, pp;
        logic signed [127:0] acc;
        pr = longint'({40'd0, raw});
        tc = longint'(temp);
        t2 = tc * tc;
        pp = pr * pr;
        // sum in units of 2^-85 Pa
        acc = scaled(cal_u16(11), 1, 88)
            + scaled(cal_u16(13), tc, 63)
            + scaled(cal_s8(15), t2, 45)
            + scaled(cal_s8(16) * tc, t2, 22)
            + scaled(pr * (cal_s16(5) - 16384), 1, 65)
            + scaled(pr * (cal_s16(7) - 16384), tc, 40)
            + scaled(cal_s8(9) * pr, t2, 21)
            + scaled(cal_s8(10) * pr * tc, t2, 0)
            + scaled(cal_s16(17), pp, 37)
            + scaled(cal_s8(19) * pp, tc, 21)
            + scaled(cal_s8(20) * pp, pr, 20);
        if (acc[127]) return '0;
        if (acc[126:103] != '0) return 24'hFFFFFF;
        return acc[102:79];
    endfunction

    task automatic compensate(t_reading r);
        t_comp c;
        if (r.t_ok) held_temp = calc_temp(r.raw_t);
        if (r.p_ok) held_pres = calc_pres(r.raw_p, held_temp);
        if (held_pres == 24'hFFFFFF || held_pres == 0 || held_temp == 24'sh7FFFFF
                || held_temp == -24'sh800000)
            n_sat++;
        c.temp = held_temp;
        c.pres = held_pres;
        comp_q.push_back(c);
    endtask

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %0s: got %06h want %06h at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                compensate(on_bus);
                n_words++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (reading_q.size() > 0 && (no_idle || $urandom_range(99) >= 38)) begin
                    on_bus = reading_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.raw_temperature <= on_bus.raw_t;
                    in_ch.raw_pressure <= on_bus.raw_p;
                    in_ch.temperature_ok <= on_bus.t_ok;
                    in_ch.pressure_ok <= on_bus.p_ok;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_comp e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (comp_q.size() == 0) begin
                    report("unexpected word", out_ch.pressure, 24'h0);
                end else begin
                    e = comp_q.pop_front();
                    if (out_ch.temperature !== e.temp)
                        report("temperature", out_ch.temperature, e.temp);
                    if (out_ch.pressure !== e.pres)
                        report("pressure", out_ch.pressure, e.pres);
                end
            end
            if (hold_go && !hold_done) begin
                hold_left = 700;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_idle || $urandom_range(99) >= 38;
            end
        end
    end

    task automatic write_cal(logic [IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == REG_CAL_LOW) cal_reg[0] = data;
        else if (idx == REG_CAL_MID) cal_reg[1] = data;
        else if (idx == REG_CAL_HIGH) cal_reg[2] = {24'd0, data[39:0]};
        @(posedge i_clk);
    endtask

    task automatic set_cal(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi);
        write_cal(REG_CAL_LOW, lo);
        write_cal(REG_CAL_MID, mid);
        write_cal(REG_CAL_HIGH, hi);
        // index past the last register must be dropped
        write_cal(2'd3, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_reading(logic [23:0] rt, logic [23:0] rp, logic tk, logic pk);
        t_reading r;
        r.raw_t = rt;
        r.raw_p = rp;
        r.t_ok = tk;
        r.p_ok = pk;
        reading_q.push_back(r);
    endtask

    task automatic add_random(int n);
        logic [23:0] rt;
        logic [31:0] center;
        repeat (n) begin
            center = 32'(cal_u16(0) * 256);
            if ($urandom_range(1)) begin
                rt = 24'($urandom);
            end else begin
                rt = 24'(center[23:0] + $urandom_range(2097151) - 1048576);
            end
            add_reading(rt, 24'($urandom), $urandom_range(99) < 70, $urandom_range(99) < 60);
        end
    endtask

    task automatic drain;
        while (reading_q.size() > 0 || in_ch.valid || comp_q.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        in_ch.temperature_ok = 1'b0;
        in_ch.pressure_ok = 1'b0;
        out_ch.ready = 1'b0;
        cal_reg[0] = '0;
        cal_reg[1] = '0;
        cal_reg[2] = '0;
        held_temp = '0;
        held_pres = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration, flags clear first: stored zeros come back
        add_reading(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        add_reading(24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
        add_reading(24'hFFFFFF, 24'h000000, 1'b1, 1'b0);
        add_reading(24'h123456, 24'hABCDEF, 1'b0, 1'b1);
        drain();

        // all ones, upper bits of the top register dropped
        set_cal('1, '1, '1);
        add_reading(24'h000000, 24'h000000, 1'b1, 1'b1);
        add_reading(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1);
        add_reading(24'h800000, 24'h7FFFFF, 1'b1, 1'b0);
        add_reading(24'h7FFFFF, 24'h800000, 1'b0, 1'b1);
        add_reading(24'h555555, 24'hAAAAAA, 1'b0, 1'b0);
        drain();

        // t1 0xFF00, t2 0x00FF, t3 zero; big offset: pressure clamps high
        set_cal(64'h00000000_00FFFF00, 64'h0000FFFF_FF000000, 64'h0);
        add_reading(24'hFFFFFF, 24'h000000, 1'b1, 1'b1);
        add_reading(24'h000000, 24'h000000, 1'b1, 1'b1);
        add_reading(24'h000100, 24'hFFFFFF, 1'b1, 1'b1);
        drain();
        // large negative sensitivity term drives pressure below zero
        set_cal(64'h00FF80FF_80FFFF00, 64'h00000000_00008000, 64'h80_0080_FF);
        add_reading(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1);
        add_reading(24'h000000, 24'hFFFFFF, 1'b1, 1'b1);
        add_reading(24'h400000, 24'h000001, 1'b0, 1'b1);
        drain();

        // plausible sensor trim, long receiver stall while words keep coming
        set_cal(64'h30FC18F94A386978, 64'h035C944CF4F506F8, 64'hF4070FA0F9);
        hold_go = 1;
        add_random(200);
        drain();

        no_idle = 1;
        add_random(150);
        drain();
        no_idle = 0;

        repeat (5) begin
            set_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
            add_random(130);
            drain();
        end

        set_cal(64'h30FC18F94A386978, 64'h035C944CF4F506F8, 64'hF4070FA0F9);
        add_random(130);
        drain();

        repeat (400) @(posedge i_clk);
        $display("%0d words in, %0d results checked, %0d at a clamp or zero, over 10 trims",
                 n_words, n_results, n_sat);
        if (n_err == 0 && comp_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("tb failed");
        $finish;
    end

endmodule

### sim.f
rtl/btpc_pkg.sv
rtl/btpc_in_if.sv
rtl/btpc_out_if.sv
rtl/btpc_datapath.sv
rtl/btpc_ctrl.sv
rtl/baro_temp_pressure_compensation.sv
tb/tb.sv
